// ===== hw/rtl/rrbd_pkg.sv =====
`timescale 1ns / 1ps

package rrbd_pkg;

	// Pins per button group
	localparam int PIN_COUNT = 8;
	localparam int PIN_IDX_W = $clog2(PIN_COUNT);

	// Defaults for the top-level parameters
	localparam int DEF_SCAN_POSITIONS = 8;
	localparam int DEF_COUNT_WIDTH    = 8;

	// Debounce threshold after reset
	localparam logic [7:0] THRESHOLD_RESET = 8'd8;

	// Pressure byte codes
	localparam logic [7:0] PRESSURE_ON  = 8'hFF;
	localparam logic [7:0] PRESSURE_OFF = 8'h00;

	typedef struct packed {
		logic [7:0] raw_buttons_first;
		logic [7:0] raw_buttons_second;
		logic       pressure_enable;
	} in_item_t;

	typedef struct packed {
		logic [7:0] debounced_first_out;
		logic [7:0] debounced_second_out;
		logic [2:0] serviced_position;
		logic [7:0] pressure_first_out;
		logic [7:0] pressure_second_out;
	} out_item_t;

	// What one lane reports for the serviced position
	typedef struct packed {
		logic [7:0] debounced;
		logic [7:0] pressure;
	} lane_res_t;

endpackage

// ===== hw/rtl/rrbd_lane.sv =====
`timescale 1ns / 1ps

module rrbd_lane
	import rrbd_pkg::*;
#(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 in_range,
	input  logic [PIN_IDX_W-1:0] pin_idx,
	input  logic [7:0]           raw,
	input  logic                 enable,
	input  logic [7:0]           threshold,
	output lane_res_t            res
);

	localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] count_q [PIN_COUNT];
	logic [7:0]             prev_q;
	logic [7:0]             deb_q;
	logic [PIN_COUNT-1:0]   flag_q;

	logic                   pin;
	logic                   changed;
	logic [COUNT_WIDTH-1:0] cnt_cur;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [COUNT_WIDTH-1:0] cnt_new;
	logic                   pressed;
	logic [7:0]             deb_new;
	logic                   flag_new;

	// Evaluate the serviced button: count, clear on change, press on threshold
	always_comb begin
		pin      = raw[pin_idx];
		changed  = (pin != prev_q[pin_idx]);
		cnt_cur  = count_q[pin_idx];
		cnt_inc  = (!pin && (cnt_cur != COUNT_MAX)) ? cnt_cur + 1'b1 : cnt_cur;
		cnt_new  = changed ? '0 : cnt_inc;
		pressed  = (CMP_W'(cnt_new) >= CMP_W'(threshold));
		deb_new  = deb_q;
		flag_new = flag_q[pin_idx];
		if (changed) begin
			deb_new[pin_idx] = 1'b1;
			if (enable) begin
				flag_new = 1'b0;
			end
		end
		if (pressed) begin
			deb_new[pin_idx] = 1'b0;
			if (enable) begin
				flag_new = 1'b1;
			end
		end
	end

	// Report post-update state; positions without a pin report the held debounced state and pressure off
	always_comb begin
		if (in_range) begin
			res.debounced = deb_new;
			res.pressure  = flag_new ? PRESSURE_ON : PRESSURE_OFF;
		end else begin
			res.debounced = deb_q;
			res.pressure  = PRESSURE_OFF;
		end
	end

	// Commit the serviced button's state on each transaction at a position with a pin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIN_COUNT; i++) begin
				count_q[i] <= '0;
			end
			prev_q <= 8'hFF;
			deb_q  <= 8'hFF;
			flag_q <= '0;
		end else if (accept && in_range) begin
			count_q[pin_idx] <= cnt_new;
			prev_q[pin_idx]  <= pin;
			deb_q            <= deb_new;
			flag_q[pin_idx]  <= flag_new;
		end
	end

endmodule

// ===== hw/rtl/rrbd_out_buf.sv =====
`timescale 1ns / 1ps

module rrbd_out_buf
	import rrbd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	output logic      full,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic      out_valid_q;
	out_item_t out_q;
	logic      skid_valid_q;
	out_item_t skid_q;
	logic      pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Hold valid flags: output register plus one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// Move payloads: drain skid first, else load the new transaction
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

endmodule

// ===== hw/rtl/round_robin_button_debouncer.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  in_data  (in_item_t)
// output    out        out_valid / out_stall out_data (out_item_t)
// config    in         cfg_wr_en            cfg_wr_data (debounce threshold)
//
// One transaction per cycle while in_stall is low: both lanes service the
// scan position in the accepting cycle and the merged result is registered.
// Reset (arst_n low) releases every button, clears counters, pressure flags
// and the scan pointer, and sets the threshold to 8.
// A stalled result waits in the output register while one more transaction
// fills the skid entry; in_stall rises only when that entry is occupied.

module round_robin_button_debouncer
	import rrbd_pkg::*;
#(
	parameter int SCAN_POSITIONS = DEF_SCAN_POSITIONS,
	parameter int COUNT_WIDTH    = DEF_COUNT_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_wr_en,
	input  logic [7:0] cfg_wr_data
);

	localparam int PTR_W = $clog2(SCAN_POSITIONS);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SCAN_POSITIONS - 1);

	logic [7:0]           threshold_q;
	logic [PTR_W-1:0]     scan_ptr_q;
	logic                 accept;
	logic                 buf_full;
	logic                 in_range;
	logic [PIN_IDX_W-1:0] pin_idx;
	lane_res_t            res_first;
	lane_res_t            res_second;
	out_item_t            merged;

	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;
	assign in_range = (32'(scan_ptr_q) < PIN_COUNT);
	assign pin_idx  = PIN_IDX_W'(scan_ptr_q);

	// Hold the debounce threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	// Advance the scan pointer on each transaction, wrapping at the last position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ptr_q <= '0;
		end else if (accept) begin
			scan_ptr_q <= (scan_ptr_q == PTR_LAST) ? '0 : scan_ptr_q + 1'b1;
		end
	end

	rrbd_lane #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_lane_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_range  (in_range),
		.pin_idx   (pin_idx),
		.raw       (in_data.raw_buttons_first),
		.enable    (in_data.pressure_enable),
		.threshold (threshold_q),
		.res       (res_first)
	);

	rrbd_lane #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_lane_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_range  (in_range),
		.pin_idx   (pin_idx),
		.raw       (in_data.raw_buttons_second),
		.enable    (in_data.pressure_enable),
		.threshold (threshold_q),
		.res       (res_second)
	);

	// Merge both lanes and the serviced position into one result
	always_comb begin
		merged.debounced_first_out  = res_first.debounced;
		merged.debounced_second_out = res_second.debounced;
		merged.serviced_position    = 3'(scan_ptr_q);
		merged.pressure_first_out   = res_first.pressure;
		merged.pressure_second_out  = res_second.pressure;
	end

	rrbd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (merged),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
